// ===== sv/bckd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bckd_pkg
// Shared widths, button masks and key codes of the button combo key decoder.
// ----------------------------------------------------------------------------
package bckd_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned QualW      = 16;
  localparam int unsigned IdleW      = 16;
  localparam int unsigned KeysW      = 8;
  localparam int unsigned CmpW       = (CountWidth > 16) ? CountWidth : 16;

  localparam int unsigned ButtonsW = 3;
  localparam int unsigned KeyCodeW = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef logic [ButtonsW-1:0] buttons_t;
  typedef logic [KeyCodeW-1:0] key_code_t;

  localparam buttons_t BtnNone = 3'b000;
  localparam buttons_t BtnVdn  = 3'b001;
  localparam buttons_t BtnVup  = 3'b010;
  localparam buttons_t BtnPwr  = 3'b100;

  localparam key_code_t KeyD     = 7'h44;
  localparam key_code_t KeyU     = 7'h55;
  localparam key_code_t KeyL     = 7'h4C;
  localparam key_code_t KeyCr    = 7'h0D;
  localparam key_code_t KeySpace = 7'h20;
  localparam key_code_t KeyTab   = 7'h09;
  localparam key_code_t KeyNone  = 7'h00;

  typedef enum logic [CfgIdxW-1:0] {
    RegQualify = 2'd0,
    RegIdle    = 2'd1,
    RegKeys    = 2'd2,
    RegUnused  = 2'd3
  } cfg_reg_e;

  localparam logic [QualW-1:0] QualifyReset = 16'd100;
  localparam logic [IdleW-1:0] IdleReset    = 16'd500;
  localparam logic [KeysW-1:0] KeysReset    = 8'd16;

endpackage

// ===== sv/bckd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bckd interfaces
// Valid/ready channels: button samples in, key words out, register writes.
// ----------------------------------------------------------------------------
interface bckd_btn_if;
  import bckd_pkg::*;
  logic     valid;
  logic     ready;
  buttons_t buttons;
  modport source (output valid, output buttons, input ready);
  modport sink (input valid, input buttons, output ready);
endinterface

interface bckd_key_if;
  import bckd_pkg::*;
  logic      valid;
  logic      ready;
  logic      has_key;
  logic      ctrl_held;
  key_code_t key_code;
  logic      session_end;
  modport source (output valid, output has_key, output ctrl_held, output key_code,
                  output session_end, input ready);
  modport sink (input valid, input has_key, input ctrl_held, input key_code,
                input session_end, output ready);
endinterface

interface bckd_cfg_if;
  import bckd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/button_combo_key_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_combo_key_decoder
// Debounces three-button samples and turns qualified presses into key words.
// ----------------------------------------------------------------------------
// One button sample is taken per cycle; its effect on the press tracker, the
// combo machine and the idle/key counters is computed in a single pass and
// any result lands in a one-word output register. A new sample is accepted
// whenever that register is empty or being read in the same cycle, so the
// sustained rate is one sample per clock; a result appears in the cycle after
// the sample that caused it. Register writes are always taken and should be
// made while no result is pending.
module button_combo_key_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  bckd_btn_if.sink        btn_i,
  bckd_key_if.source      key_o,
  bckd_cfg_if.sink        cfg_i
);
  import bckd_pkg::*;

  typedef enum logic [1:0] {PhWait, PhHold, PhRelease} phase_e;
  typedef enum logic {CsStart, CsS1} combo_e;

  logic [QualW-1:0]      qual_q;
  logic [IdleW-1:0]      idle_cfg_q;
  logic [KeysW-1:0]      keys_cfg_q;

  phase_e                phase_q, phase_d;
  combo_e                combo_q, combo_d;
  buttons_t              cand_q, cand_d;
  logic [CountWidth-1:0] hold_q, hold_d;
  logic [CountWidth-1:0] idle_q, idle_d;
  logic [KeysW-1:0]      kcnt_q, kcnt_d;

  logic                  out_valid_q;
  logic                  has_key_q, ctrl_q, end_q;
  key_code_t             code_q;

  logic                  in_fire, res_valid, res_key, res_ctrl, res_end;
  key_code_t             res_code;
  logic                  combo_key, combo_ctrl;
  key_code_t             combo_code;
  combo_e                combo_nxt;
  logic                  check_idle;
  logic [CountWidth-1:0] idle_inc, hold_inc;
  logic [KeysW-1:0]      kcnt_inc;
  logic [QualW-1:0]      qual_min;
  logic [IdleW-1:0]      idle_min;
  logic [KeysW-1:0]      keys_min;
  buttons_t              b;

  assign btn_i.ready = !out_valid_q || key_o.ready;
  assign in_fire     = btn_i.valid && btn_i.ready;
  assign cfg_i.ready = 1'b1;
  assign b           = btn_i.buttons;

  assign qual_min = (qual_q == '0) ? QualW'(1) : qual_q;
  assign idle_min = (idle_cfg_q == '0) ? IdleW'(1) : idle_cfg_q;
  assign keys_min = (keys_cfg_q == '0) ? KeysW'(1) : keys_cfg_q;
  assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign hold_inc = (hold_q == '1) ? hold_q : hold_q + 1'b1;
  assign kcnt_inc = kcnt_q + 1'b1;

  // combo machine on the candidate pattern
  always_comb begin
    combo_key  = 1'b0;
    combo_ctrl = 1'b0;
    combo_code = KeyNone;
    combo_nxt  = CsStart;
    unique case (combo_q)
      CsStart: begin
        unique case (cand_q)
          BtnPwr | BtnVup: begin
            combo_key = 1'b1; combo_ctrl = 1'b1; combo_code = KeyD;
          end
          BtnPwr | BtnVdn: begin
            combo_key = 1'b1; combo_ctrl = 1'b1; combo_code = KeyU;
          end
          BtnVup: begin
            combo_key = 1'b1; combo_code = KeyCr;
          end
          BtnVdn: begin
            combo_key = 1'b1; combo_code = KeySpace;
          end
          BtnPwr: combo_nxt = CsS1;
          default: ;
        endcase
      end
      CsS1: begin
        unique case (cand_q)
          BtnVup: begin
            combo_key = 1'b1; combo_ctrl = 1'b1; combo_code = KeyL;
          end
          BtnVdn: begin
            combo_key = 1'b1; combo_code = KeyTab;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    combo_d    = combo_q;
    cand_d     = cand_q;
    hold_d     = hold_q;
    idle_d     = idle_q;
    kcnt_d     = kcnt_q;
    res_valid  = 1'b0;
    res_key    = 1'b0;
    res_ctrl   = 1'b0;
    res_code   = KeyNone;
    res_end    = 1'b0;
    check_idle = 1'b0;
    unique case (phase_q)
      PhRelease: begin
        if (b != cand_q) begin
          phase_d = PhWait;
          idle_d  = '0;
          hold_d  = '0;
          combo_d = combo_nxt;
          if (combo_key) begin
            res_valid = 1'b1;
            res_key   = 1'b1;
            res_ctrl  = combo_ctrl;
            res_code  = combo_code;
            kcnt_d    = kcnt_inc;
            res_end   = kcnt_inc >= keys_min;
          end
        end
      end
      PhWait: begin
        idle_d = idle_inc;
        if (b == BtnNone) begin
          check_idle = 1'b1;
        end else begin
          cand_d  = b;
          hold_d  = CountWidth'(1);
          phase_d = (qual_min == QualW'(1)) ? PhRelease : PhHold;
        end
      end
      PhHold: begin
        idle_d = idle_inc;
        if (b != cand_q) begin
          phase_d    = PhWait;
          hold_d     = '0;
          check_idle = 1'b1;
        end else begin
          hold_d = hold_inc;
          if (CmpW'(hold_inc) >= CmpW'(qual_min)) begin
            phase_d = PhRelease;
          end
        end
      end
      default: ;
    endcase
    if (check_idle && (CmpW'(idle_inc) >= CmpW'(idle_min))) begin
      res_valid = 1'b1;
      res_end   = 1'b1;
    end
    if (res_end) begin
      phase_d = PhWait;
      combo_d = CsStart;
      cand_d  = BtnNone;
      hold_d  = '0;
      idle_d  = '0;
      kcnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qual_q     <= QualifyReset;
      idle_cfg_q <= IdleReset;
      keys_cfg_q <= KeysReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        RegQualify: qual_q     <= cfg_i.data;
        RegIdle:    idle_cfg_q <= cfg_i.data;
        RegKeys:    keys_cfg_q <= cfg_i.data[KeysW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhWait;
      combo_q     <= CsStart;
      cand_q      <= BtnNone;
      hold_q      <= '0;
      idle_q      <= '0;
      kcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        combo_q <= combo_d;
        cand_q  <= cand_d;
        hold_q  <= hold_d;
        idle_q  <= idle_d;
        kcnt_q  <= kcnt_d;
      end
      if (in_fire) begin
        out_valid_q <= res_valid;
      end else if (key_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      has_key_q <= res_key;
      ctrl_q    <= res_ctrl;
      code_q    <= res_code;
      end_q     <= res_end;
    end
  end

  assign key_o.valid       = out_valid_q;
  assign key_o.has_key     = has_key_q;
  assign key_o.ctrl_held   = ctrl_q;
  assign key_o.key_code    = code_q;
  assign key_o.session_end = end_q;

  a_timeout_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_o.valid && !key_o.has_key |-> key_o.session_end)
    else $error("word without key must end the session");

  a_key_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_o.valid && key_o.has_key |-> key_o.key_code != KeyNone)
    else $error("key word with empty code");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_end |=> kcnt_q == '0 && idle_q == '0 && combo_q == CsStart)
    else $error("session end did not clear counters");

  a_release_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhRelease |-> cand_q != BtnNone)
    else $error("release phase with empty candidate");

endmodule
